// ===== hw/rtl/bsc_pkg.sv =====
// Package for the breakpoint step controller: sizes, codes and the
// transaction and table entry types. No dependencies.
`timescale 1ns / 1ps
package bsc_pkg;

  localparam int MAX_BREAKPOINTS = 16;
  localparam int IDX_W = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
  localparam int CNT_W = $clog2(MAX_BREAKPOINTS + 1);

  localparam logic [2:0] MODE_LINE     = 3'd0;
  localparam logic [2:0] MODE_CONTINUE = 3'd1;
  localparam logic [2:0] MODE_OVER     = 3'd2;
  localparam logic [2:0] MODE_INTO     = 3'd3;
  localparam logic [2:0] MODE_OUT      = 3'd4;
  localparam logic [2:0] MODE_ADD      = 3'd5;
  localparam logic [2:0] MODE_REMOVE   = 3'd6;

  localparam logic [2:0] RM_RUNNING = 3'd0;
  localparam logic [2:0] RM_HALTED  = 3'd1;
  localparam logic [2:0] RM_OVER    = 3'd2;
  localparam logic [2:0] RM_INTO    = 3'd3;
  localparam logic [2:0] RM_OUT     = 3'd4;

  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_FIBER = 2'd1;
  localparam logic [1:0] CAUSE_STEP  = 2'd2;
  localparam logic [1:0] CAUSE_BP    = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  module_id;
    logic [15:0] line_number;
    logic [7:0]  frame_depth;
    logic [7:0]  fiber_id;
  } cmd_t;

  typedef struct packed {
    logic        stop;
    logic [1:0]  stop_cause;
    logic [2:0]  run_state;
    logic        op_ok;
    logic [15:0] bp_id;
  } rsp_t;

  // armed is -1 while the breakpoint has not fired.
  typedef struct packed {
    logic [15:0]       line;
    logic [7:0]        module_id;
    logic [15:0]       id;
    logic signed [8:0] armed;
  } bp_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    bp_entry_t        wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hw/rtl/breakpoint_step_controller_unit.sv =====
// Top level of the breakpoint step controller: command sequencer and run state.
// Depends on bsc_pkg and bsc_bp_table.
// Run commands, unused modes and line events while halted skip the table sweep;
// other line events, add and remove sweep the table one entry a cycle, and a
// remove of a match then moves the last entry into the freed slot. A new start is
// taken once busy falls. The receiver cannot stall. Synchronous reset clears the
// run state and the table count; table contents are undefined until written.
`timescale 1ns / 1ps
module breakpoint_step_controller_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bsc_pkg::cmd_t cmd,
  output logic          done,
  output bsc_pkg::rsp_t rsp
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_FINISH  = 3'd2;
  localparam logic [2:0] S_MOVE_RD = 3'd3;
  localparam logic [2:0] S_MOVE_WR = 3'd4;

  logic [2:0] state;
  bsc_pkg::cmd_t cmd_q;

  logic [2:0]         run_mode;
  logic signed [16:0] prev_line;
  logic signed [8:0]  prev_depth;
  logic signed [16:0] step_origin_line;
  logic signed [8:0]  step_origin_depth;
  logic signed [8:0]  step_out_target;
  logic [7:0]         prev_fiber;
  logic [bsc_pkg::CNT_W-1:0] bp_count;
  logic [15:0]        next_bp_id;

  logic [bsc_pkg::CNT_W-1:0] rd_idx;
  logic                      rd_valid;
  logic [bsc_pkg::IDX_W-1:0] wr_idx;
  logic                      found;
  logic [bsc_pkg::IDX_W-1:0] found_idx;

  bsc_pkg::mem_req_t  req;
  bsc_pkg::bp_entry_t q;

  bsc_bp_table u_table (
    .clk (clk),
    .req (req),
    .q   (q)
  );

  logic signed [8:0]  d9;
  logic signed [16:0] l17;
  logic               fiber_sw;
  logic               moved;
  logic [1:0]         pre_cause;
  logic               scan_en;
  logic               issue;
  logic               match;
  logic               hit;
  logic signed [8:0]  armed_new;
  logic [bsc_pkg::CNT_W-1:0] last_cnt;
  logic               add_ok;
  logic               remove_move;
  logic [2:0]         run_mode_next;
  bsc_pkg::rsp_t      rsp_next;

  assign d9       = {1'b0, cmd_q.frame_depth};
  assign l17      = {1'b0, cmd_q.line_number};
  assign fiber_sw = cmd_q.fiber_id != prev_fiber;
  assign moved    = (l17 != prev_line) || (d9 != prev_depth);
  assign issue    = rd_idx < bp_count;
  assign match    = (q.line == cmd_q.line_number) && (q.module_id == cmd_q.module_id);
  assign last_cnt = bp_count - 1'b1;
  assign add_ok   = cmd_q.mode == bsc_pkg::MODE_ADD && !found &&
                    bp_count < bsc_pkg::CNT_W'(bsc_pkg::MAX_BREAKPOINTS);
  assign remove_move = cmd_q.mode == bsc_pkg::MODE_REMOVE && found;

  // Decision that needs no table access; the sweep can only find a breakpoint hit when none fires.
  always_comb begin
    pre_cause = bsc_pkg::CAUSE_NONE;
    scan_en   = 1'b0;
    if (run_mode != bsc_pkg::RM_RUNNING && fiber_sw) begin
      pre_cause = bsc_pkg::CAUSE_FIBER;
    end else if (run_mode == bsc_pkg::RM_OVER && d9 == step_origin_depth) begin
      pre_cause = (l17 != step_origin_line) ? bsc_pkg::CAUSE_STEP : bsc_pkg::CAUSE_NONE;
    end else if (run_mode == bsc_pkg::RM_INTO && moved) begin
      pre_cause = bsc_pkg::CAUSE_STEP;
    end else if (run_mode == bsc_pkg::RM_OUT && d9 == step_out_target) begin
      pre_cause = bsc_pkg::CAUSE_STEP;
    end else begin
      scan_en = moved;
    end
  end

  always_comb begin
    hit = scan_en && !found && (q.armed < d9) && match;
    armed_new = hit ? d9 : q.armed;
    if (fiber_sw || (d9 != prev_depth && armed_new > d9)) begin
      armed_new = -9'sd1;
    end
  end

  // Result and next run mode once the sweep is over.
  always_comb begin
    run_mode_next = run_mode;
    rsp_next      = '0;
    case (cmd_q.mode)
      bsc_pkg::MODE_LINE: begin
        if (run_mode != bsc_pkg::RM_HALTED &&
            (pre_cause != bsc_pkg::CAUSE_NONE || found)) begin
          rsp_next.stop       = 1'b1;
          rsp_next.stop_cause = (pre_cause != bsc_pkg::CAUSE_NONE) ?
                                pre_cause : bsc_pkg::CAUSE_BP;
          run_mode_next       = bsc_pkg::RM_HALTED;
        end
      end
      bsc_pkg::MODE_CONTINUE: begin
        if (run_mode == bsc_pkg::RM_HALTED) begin
          run_mode_next  = bsc_pkg::RM_RUNNING;
          rsp_next.op_ok = 1'b1;
        end
      end
      bsc_pkg::MODE_INTO: begin
        if (run_mode == bsc_pkg::RM_HALTED) begin
          run_mode_next  = bsc_pkg::RM_INTO;
          rsp_next.op_ok = 1'b1;
        end
      end
      bsc_pkg::MODE_OVER: begin
        if (run_mode == bsc_pkg::RM_HALTED) begin
          run_mode_next  = bsc_pkg::RM_OVER;
          rsp_next.op_ok = 1'b1;
        end
      end
      bsc_pkg::MODE_OUT: begin
        if (run_mode == bsc_pkg::RM_HALTED && prev_depth > 9'sd0) begin
          run_mode_next  = bsc_pkg::RM_OUT;
          rsp_next.op_ok = 1'b1;
        end
      end
      bsc_pkg::MODE_ADD: begin
        if (add_ok) begin
          rsp_next.op_ok = 1'b1;
          rsp_next.bp_id = next_bp_id;
        end
      end
      bsc_pkg::MODE_REMOVE: begin
        rsp_next.op_ok = found;
      end
      default: begin
      end
    endcase
    rsp_next.run_state = run_mode_next;
  end

  always_comb begin
    req.we    = 1'b0;
    req.waddr = wr_idx;
    req.wdata = q;
    req.raddr = rd_idx[bsc_pkg::IDX_W-1:0];
    unique case (state)
      S_SCAN: begin
        if (rd_valid && cmd_q.mode == bsc_pkg::MODE_LINE) begin
          req.we          = 1'b1;
          req.wdata.armed = armed_new;
        end
      end
      S_FINISH: begin
        req.waddr = bp_count[bsc_pkg::IDX_W-1:0];
        req.wdata = '{line: cmd_q.line_number, module_id: cmd_q.module_id,
                      id: next_bp_id, armed: -9'sd1};
        req.we    = add_ok;
      end
      S_MOVE_RD: begin
        req.raddr = last_cnt[bsc_pkg::IDX_W-1:0];
      end
      S_MOVE_WR: begin
        req.we    = 1'b1;
        req.waddr = found_idx;
      end
      default: begin
      end
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      run_mode          <= bsc_pkg::RM_RUNNING;
      prev_line         <= -17'sd1;
      prev_depth        <= -9'sd1;
      step_origin_line  <= -17'sd1;
      step_origin_depth <= -9'sd1;
      step_out_target   <= -9'sd1;
      prev_fiber        <= '0;
      bp_count          <= '0;
      next_bp_id        <= '0;
      rd_idx            <= '0;
      rd_valid          <= 1'b0;
      found             <= 1'b0;
      done              <= 1'b0;
    end else begin
      done <= (state == S_FINISH && !remove_move) || state == S_MOVE_WR;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q    <= cmd;
            rd_idx   <= '0;
            rd_valid <= 1'b0;
            found    <= 1'b0;
            if ((cmd.mode == bsc_pkg::MODE_LINE && run_mode != bsc_pkg::RM_HALTED) ||
                cmd.mode == bsc_pkg::MODE_ADD || cmd.mode == bsc_pkg::MODE_REMOVE) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          rd_valid <= issue;
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
            wr_idx <= rd_idx[bsc_pkg::IDX_W-1:0];
          end
          if (rd_valid) begin
            if (cmd_q.mode == bsc_pkg::MODE_LINE) begin
              if (hit) begin
                found <= 1'b1;
              end
            end else if (match && !found) begin
              found     <= 1'b1;
              found_idx <= wr_idx;
            end
          end
          if (!issue && !rd_valid) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          rsp      <= rsp_next;
          run_mode <= run_mode_next;
          // The last entry moves into the freed slot before the result goes out.
          state    <= remove_move ? S_MOVE_RD : S_IDLE;
          if (cmd_q.mode == bsc_pkg::MODE_LINE && run_mode != bsc_pkg::RM_HALTED) begin
            prev_fiber <= cmd_q.fiber_id;
            prev_depth <= d9;
            prev_line  <= l17;
          end
          if (cmd_q.mode == bsc_pkg::MODE_OVER && rsp_next.op_ok) begin
            step_origin_line  <= prev_line;
            step_origin_depth <= prev_depth;
          end
          if (cmd_q.mode == bsc_pkg::MODE_OUT && rsp_next.op_ok) begin
            step_out_target <= prev_depth - 9'sd1;
          end
          if (add_ok) begin
            next_bp_id <= next_bp_id + 16'd1;
            bp_count   <= bp_count + 1'b1;
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          bp_count <= last_cnt;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/bsc_bp_table.sv =====
// Breakpoint table memory: one write port, one read port, registered read.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_bp_table (
  input  logic               clk,
  input  bsc_pkg::mem_req_t  req,
  output bsc_pkg::bp_entry_t q
);

  bsc_pkg::bp_entry_t mem [bsc_pkg::MAX_BREAKPOINTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    q <= mem[req.raddr];
  end

endmodule
